### hdl/multi_pattern_occurrence_counter_assert.svh
// assertion macros shared by the checker
`ifndef MULTI_PATTERN_OCCURRENCE_COUNTER_ASSERT_SVH
`define MULTI_PATTERN_OCCURRENCE_COUNTER_ASSERT_SVH

// same-cycle implication, off during reset
`define MPOC_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("mpoc check failed");

// next-cycle implication, off during reset
`define MPOC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mpoc check failed");

`endif

### hdl/mpoc_pkg.sv
package mpoc_pkg;

  localparam int SLOT_COUNT          = 4;
  localparam int SLOT_W              = 2;
  localparam int DEF_PATTERN_COUNT   = 4;
  localparam int DEF_MAX_PATTERN_LEN = 8;
  localparam int DEF_TOTAL_WIDTH     = 32;

  localparam int BYTE_W      = 8;
  localparam int PATTERN_W   = 64;
  localparam int LEN_W       = 4;
  localparam int OUT_TOTAL_W = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_USED_W  = SLOT_COUNT + SLOT_COUNT * OUT_TOTAL_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PAT_A = 3'd0,
    REG_PAT_B = 3'd1,
    REG_PAT_C = 3'd2,
    REG_PAT_D = 3'd3,
    REG_LEN_A = 3'd4,
    REG_LEN_B = 3'd5,
    REG_LEN_C = 3'd6,
    REG_LEN_D = 3'd7
  } cfg_reg_t;

  // per-word control from the pipeline to the text state
  typedef struct packed {
    logic step;  // word leaves the input register this cycle
    logic last;  // that word ends the text
  } step_ctl_t;

endpackage

### hdl/mpoc_window.sv
module mpoc_window #(
  parameter int MAX_PATTERN_LEN = mpoc_pkg::DEF_MAX_PATTERN_LEN,
  localparam int FILL_W = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  mpoc_pkg::step_ctl_t                         ctl,
  input  logic [mpoc_pkg::BYTE_W-1:0]                 cur_byte,
  output logic [MAX_PATTERN_LEN-1:0][mpoc_pkg::BYTE_W-1:0] window,
  output logic [FILL_W-1:0]                           fill
);
  import mpoc_pkg::*;

  localparam int HIST_D = (MAX_PATTERN_LEN > 1) ? MAX_PATTERN_LEN - 1 : 1;

  logic [HIST_D-1:0][BYTE_W-1:0] recent;
  logic [HIST_D-1:0][BYTE_W-1:0] recent_next;

  // history bytes beyond fill never count toward a hit, so they need no clear
  always_comb begin
    recent_next[0] = cur_byte;
    for (int k = 1; k < HIST_D; k++) begin
      recent_next[k] = recent[k-1];
    end
  end

  always_comb begin
    window[0] = cur_byte;
    for (int k = 1; k < MAX_PATTERN_LEN; k++) begin
      window[k] = recent[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      recent <= recent_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ctl.step) begin
      if (ctl.last) begin
        fill <= '0;
      end else if (fill < FILL_W'(MAX_PATTERN_LEN - 1)) begin
        fill <= fill + FILL_W'(1);
      end
    end
  end

endmodule

### hdl/mpoc_match.sv
module mpoc_match #(
  parameter int MAX_PATTERN_LEN = mpoc_pkg::DEF_MAX_PATTERN_LEN,
  localparam int FILL_W = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1
) (
  input  logic [MAX_PATTERN_LEN-1:0][mpoc_pkg::BYTE_W-1:0] window,
  input  logic [FILL_W-1:0]                           fill,
  input  logic [mpoc_pkg::PATTERN_W-1:0]              pattern,
  input  logic [mpoc_pkg::LEN_W-1:0]                  len,
  output logic                                        hit
);
  import mpoc_pkg::*;

  // one comparator set per possible length, the configured length picks one
  always_comb begin
    logic ok;
    hit = 1'b0;
    for (int l = 1; l <= MAX_PATTERN_LEN; l++) begin
      ok = 1'b1;
      for (int i = 0; i < l; i++) begin
        if (window[l-1-i] != pattern[BYTE_W*i +: BYTE_W]) begin
          ok = 1'b0;
        end
      end
      if (ok && len == LEN_W'(l) && fill >= FILL_W'(l - 1)) begin
        hit = 1'b1;
      end
    end
  end

endmodule

### hdl/mpoc_totals.sv
module mpoc_totals #(
  parameter int PATTERN_COUNT = mpoc_pkg::DEF_PATTERN_COUNT,
  parameter int TOTAL_WIDTH   = mpoc_pkg::DEF_TOTAL_WIDTH
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  mpoc_pkg::step_ctl_t                     ctl,
  input  logic [PATTERN_COUNT-1:0]                hit,
  output logic [PATTERN_COUNT-1:0][TOTAL_WIDTH-1:0] total_next
);
  import mpoc_pkg::*;

  logic [PATTERN_COUNT-1:0][TOTAL_WIDTH-1:0] totals;

  // saturating increment
  always_comb begin
    for (int p = 0; p < PATTERN_COUNT; p++) begin
      if (hit[p] && totals[p] != '1) begin
        total_next[p] = totals[p] + TOTAL_WIDTH'(1);
      end else begin
        total_next[p] = totals[p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      totals <= '0;
    end else if (ctl.step) begin
      if (ctl.last) begin
        totals <= '0;
      end else begin
        totals <= total_next;
      end
    end
  end

endmodule

### hdl/multi_pattern_occurrence_counter.sv
// Counts every occurrence, overlaps included, of up to four patterns of up
// to eight bytes in a text that streams in one byte per word. Registers 0..3
// hold the pattern bytes (first character in the low byte), registers 4..7
// the lengths in the low four bits; length zero or above the maximum
// disables a pattern. Each input word (tdata = text byte, tlast = last byte
// of the text) gives one output word with a hit flag and a saturating running
// total per pattern; tlast on the output marks the word whose totals are final
// for the text, after which window and totals start over. Throughput is one
// word per clock while the output side takes results; each word passes the input
// register, then the result register, and the only stall is back-pressure from
// the output side. Write configuration only while no word is in flight.
module multi_pattern_occurrence_counter #(
  parameter int PATTERN_COUNT   = mpoc_pkg::DEF_PATTERN_COUNT,
  parameter int MAX_PATTERN_LEN = mpoc_pkg::DEF_MAX_PATTERN_LEN,
  parameter int TOTAL_WIDTH     = mpoc_pkg::DEF_TOTAL_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  // text in
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [mpoc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // [7:0] text_byte
  input  logic                               s_axis_tlast,   // end_of_text
  // results out
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] hit_a, [1] hit_b, [2] hit_c, [3] hit_d, [35:4] total_a,
  // [67:36] total_b, [99:68] total_c, [131:100] total_d, [135:132] zero
  output logic [mpoc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                               m_axis_tlast,   // text_done
  // configuration writes
  input  logic                               cfg_we,
  input  logic [mpoc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mpoc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mpoc_pkg::*;

  localparam int FILL_W = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;

  // pattern registers, one per implemented slot
  logic [PATTERN_COUNT-1:0][PATTERN_W-1:0] pat_bytes;
  logic [PATTERN_COUNT-1:0][LEN_W-1:0]     pat_len;
  logic                                    bytes_we;
  logic                                    len_we;
  logic [SLOT_W-1:0]                       cfg_slot;

  // input register
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;

  // result register
  logic                                    out_valid;
  logic [SLOT_COUNT-1:0]                   out_hit;
  logic [SLOT_COUNT-1:0][OUT_TOTAL_W-1:0]  out_total;
  logic                                    out_last;

  // datapath between the two registers
  logic                                        advance;
  step_ctl_t                                   ctl;
  logic [MAX_PATTERN_LEN-1:0][BYTE_W-1:0]      window;
  logic [FILL_W-1:0]                           fill;
  logic [PATTERN_COUNT-1:0]                    hit;
  logic [PATTERN_COUNT-1:0][TOTAL_WIDTH-1:0]   total_next;
  logic [SLOT_COUNT-1:0]                       slot_hit;
  logic [SLOT_COUNT-1:0][OUT_TOTAL_W-1:0]      slot_total;

  // ---- configuration decode
  assign cfg_slot = cfg_index[SLOT_W-1:0];

  always_comb begin
    bytes_we = 1'b0;
    len_we   = 1'b0;
    case (cfg_reg_t'(cfg_index))
      REG_PAT_A, REG_PAT_B, REG_PAT_C, REG_PAT_D: bytes_we = cfg_we;
      REG_LEN_A, REG_LEN_B, REG_LEN_C, REG_LEN_D: len_we   = cfg_we;
      default: begin
        bytes_we = 1'b0;
        len_we   = 1'b0;
      end
    endcase
  end

  // writes to slots beyond PATTERN_COUNT fall on no register
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_bytes <= '0;
      pat_len   <= '0;
    end else begin
      for (int p = 0; p < PATTERN_COUNT; p++) begin
        if (bytes_we && cfg_slot == SLOT_W'(p)) begin
          pat_bytes[p] <= cfg_data;
        end
        if (len_we && cfg_slot == SLOT_W'(p)) begin
          pat_len[p] <= cfg_data[LEN_W-1:0];
        end
      end
    end
  end

  // ---- handshake: the result register moves whenever it is empty or taken
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign ctl.step      = in_valid && advance;
  assign ctl.last      = in_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata[BYTE_W-1:0];
      in_last <= s_axis_tlast;
    end
  end

  // ---- window of recent bytes and how much of it belongs to this text
  mpoc_window #(
    .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
  ) u_window (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .cur_byte(in_byte),
    .window  (window),
    .fill    (fill)
  );

  // ---- one comparator bank per pattern, all in parallel
  for (genvar p = 0; p < PATTERN_COUNT; p++) begin : g_match
    mpoc_match #(
      .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
    ) u_match (
      .window (window),
      .fill   (fill),
      .pattern(pat_bytes[p]),
      .len    (pat_len[p]),
      .hit    (hit[p])
    );
  end

  // ---- running totals, cleared after the last byte of a text
  mpoc_totals #(
    .PATTERN_COUNT(PATTERN_COUNT),
    .TOTAL_WIDTH  (TOTAL_WIDTH)
  ) u_totals (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .hit       (hit),
    .total_next(total_next)
  );

  // unused slots report zero; totals show their low 32 bits
  for (genvar s = 0; s < SLOT_COUNT; s++) begin : g_slot
    if (s < PATTERN_COUNT) begin : g_used
      assign slot_hit[s]   = hit[s];
      assign slot_total[s] = OUT_TOTAL_W'(total_next[s]);
    end else begin : g_unused
      assign slot_hit[s]   = 1'b0;
      assign slot_total[s] = '0;
    end
  end

  // ---- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      out_hit   <= slot_hit;
      out_total <= slot_total;
      out_last  <= in_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {OUT_PAD_W'(0), out_total, out_hit};
  assign m_axis_tlast  = out_last;

endmodule

### hdl/mpoc_checker.sv
`include "multi_pattern_occurrence_counter_assert.svh"

module mpoc_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [mpoc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tlast
);
  import mpoc_pkg::*;

  // a stalled result word holds
  `MPOC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // input side only stalls behind a result word that is not taken
  `MPOC_ASSERT_IMPLY(a_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

  // every word taken is followed by a valid result word, through the input and result registers
  `MPOC_ASSERT_IMPLY(a_result_due, s_axis_tvalid && s_axis_tready, ##2 m_axis_tvalid)

  // padding above the totals stays zero
  `MPOC_ASSERT_IMPLY(a_pad_zero, m_axis_tvalid, m_axis_tdata[OUT_TDATA_W-1 -: OUT_PAD_W] == '0)

endmodule

bind multi_pattern_occurrence_counter mpoc_checker u_mpoc_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);
